FILE: rtl/core/ssrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo sweep range scanner package
// Widths, register indexes, reset values and fixed-point constants shared by
// the scanner modules.
// ----------------------------------------------------------------------------
package ssrs_pkg;

    localparam int TIME_W    = 32;
    localparam int IVAL_W    = 16;
    localparam int ECHO_W    = 16;
    localparam int ANGLE_W   = 8;
    localparam int WIDTH_W   = 11;
    localparam int DIST_W    = 11;
    localparam int CFG_IDX_W = 8;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 32;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
    localparam logic [WIDTH_W-1:0] WIDTH_MIN = 11'd1000;

    // angle*1000/180 equals floor(angle * 728200 / 2^17) for every angle 0..180.
    localparam int                 WIDTH_PROD_W = 28;
    localparam logic [19:0]        WIDTH_RECIP  = 20'd728200;
    localparam int                 WIDTH_SHIFT  = 17;

    // echo*343/20000 equals floor(echo * 343 * 54975582 / 2^40) for every
    // 16-bit echo; the two constant factors are merged into one.
    localparam int                 DIST_PROD_W = 51;
    localparam logic [34:0]        DIST_RECIP  = 35'd18856624626;
    localparam int                 DIST_SHIFT  = 40;

    localparam logic [IVAL_W-1:0]  PULSE_IVAL_RST   = 16'd20;
    localparam logic [IVAL_W-1:0]  STEP_IVAL_RST    = 16'd30;
    localparam logic [IVAL_W-1:0]  SAMPLE_IVAL_RST  = 16'd70;
    localparam logic [ECHO_W-1:0]  ECHO_TIMEOUT_RST = 16'd8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PULSE_IVAL   = 8'd0,
        REG_STEP_IVAL    = 8'd1,
        REG_SAMPLE_IVAL  = 8'd2,
        REG_ECHO_TIMEOUT = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic pulse;
        logic step;
        logic sample;
    } tick_fire_t;

endpackage

FILE: rtl/core/servo_sweep_range_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo sweep range scanner
// Per millisecond tick: servo refresh pulse timing, back-and-forth sweep of
// the servo angle with its pulse width, and timed range samples from echoes.
//
//   Channel   Direction   Payload
//   s_axis    in          now_ms, echo_us
//   m_axis    out         pulse_fire, pulse_width_us, sample_fire,
//                         sample_angle, distance_cm
//   cfg_wr    in          four 16-bit interval and timeout registers
//
// An item moves from the input register directly into the result register,
// so one item is taken every cycle while m_axis is not stalled; the result
// is valid once the item has passed the input and result registers. The
// timer and sweep state updates of one item are ready for the next item in
// the following cycle. A stall on m_axis holds the result register, and the
// input register still takes one item behind it. Reset clears the pipeline,
// the timers and the sweep, and loads the register defaults.
// ----------------------------------------------------------------------------
module servo_sweep_range_scanner_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] now_ms, [47:32] echo_us
    input  logic [ssrs_pkg::IN_W-1:0]       s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] pulse_fire, [11:1] pulse_width_us, [12] sample_fire,
    // [20:13] sample_angle, [31:21] distance_cm
    output logic [ssrs_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                            cfg_wr_en,
    input  logic [ssrs_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [ssrs_pkg::IVAL_W-1:0]     cfg_wr_data
);
    import ssrs_pkg::*;

    logic [IVAL_W-1:0] pulse_ival_reg;
    logic [IVAL_W-1:0] step_ival_reg;
    logic [IVAL_W-1:0] sample_ival_reg;
    logic [ECHO_W-1:0] echo_timeout_reg;

    logic              in_valid_reg;
    logic [TIME_W-1:0] now_reg;
    logic [ECHO_W-1:0] echo_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [OUT_W-1:0]  out_data_next;

    logic              advance;
    logic              proc;
    tick_fire_t        fire;
    logic [ANGLE_W-1:0] angle_after;
    logic [WIDTH_W-1:0] width_before;
    logic [DIST_W-1:0]  distance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_ival_reg   <= PULSE_IVAL_RST;
            step_ival_reg    <= STEP_IVAL_RST;
            sample_ival_reg  <= SAMPLE_IVAL_RST;
            echo_timeout_reg <= ECHO_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_PULSE_IVAL:   pulse_ival_reg   <= cfg_wr_data;
                REG_STEP_IVAL:    step_ival_reg    <= cfg_wr_data;
                REG_SAMPLE_IVAL:  sample_ival_reg  <= cfg_wr_data;
                REG_ECHO_TIMEOUT: echo_timeout_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // The result register frees up when empty or when its transfer completes.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            now_reg  <= s_axis_tdata[TIME_W-1:0];
            echo_reg <= s_axis_tdata[TIME_W +: ECHO_W];
        end
    end

    ssrs_timer u_pulse_timer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .now_ms      (now_reg),
        .interval_ms (pulse_ival_reg),
        .update      (proc),
        .fire        (fire.pulse)
    );

    ssrs_timer u_step_timer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .now_ms      (now_reg),
        .interval_ms (step_ival_reg),
        .update      (proc),
        .fire        (fire.step)
    );

    ssrs_timer u_sample_timer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .now_ms      (now_reg),
        .interval_ms (sample_ival_reg),
        .update      (proc),
        .fire        (fire.sample)
    );

    ssrs_sweep u_sweep (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (proc && fire.step),
        .angle_after  (angle_after),
        .width_before (width_before)
    );

    ssrs_range u_range (
        .echo_us         (echo_reg),
        .echo_timeout_us (echo_timeout_reg),
        .sample          (fire.sample),
        .distance_cm     (distance)
    );

    assign out_data_next = {distance, angle_after, fire.sample, width_before, fire.pulse};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The sweep never leaves 0..180 degrees.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[20:13] <= ANGLE_MAX))
        else $error("sample_angle above 180 degrees");

    // The pulse width stays within 1000..2000 microseconds.
    a_width_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ((m_axis_tdata[11:1] >= WIDTH_MIN)
                           && (m_axis_tdata[11:1] <= 11'd2000)))
        else $error("pulse_width_us out of range");

    // A distance is only reported with a sample.
    a_dist_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tdata[12]) |-> (m_axis_tdata[31:21] == '0))
        else $error("distance_cm nonzero without sample_fire");

    // A processed item always lands in the result register.
    a_proc_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        proc |=> out_valid_reg)
        else $error("processed item lost before the result register");

endmodule

FILE: rtl/core/ssrs_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanner interval timer
// Fires when the wrap-safe elapsed time since the last firing reaches the
// interval, and on an update records the current time as the last firing.
// ----------------------------------------------------------------------------
module ssrs_timer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ssrs_pkg::TIME_W-1:0]  now_ms,
    input  logic [ssrs_pkg::IVAL_W-1:0]  interval_ms,
    input  logic                         update,
    output logic                         fire
);
    import ssrs_pkg::*;

    logic [TIME_W-1:0] last_reg;
    logic [TIME_W-1:0] last_next;
    logic [TIME_W-1:0] elapsed;

    // Unsigned subtraction modulo 2^32 handles the time counter wrapping.
    assign elapsed = now_ms - last_reg;
    assign fire    = elapsed >= TIME_W'(interval_ms);

    always_comb begin
        last_next = last_reg;
        if (update && fire) begin
            last_next = now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
        end else begin
            last_reg <= last_next;
        end
    end

endmodule

FILE: rtl/core/ssrs_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanner sweep stepper
// Holds the servo angle, sweep direction and pulse width, and moves the angle
// one degree per step between 0 and 180 degrees.
// ----------------------------------------------------------------------------
module ssrs_sweep (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    output logic [ssrs_pkg::ANGLE_W-1:0]  angle_after,
    output logic [ssrs_pkg::WIDTH_W-1:0]  width_before
);
    import ssrs_pkg::*;

    logic [ANGLE_W-1:0]      angle_reg;
    logic [ANGLE_W-1:0]      angle_next;
    logic                    dir_down_reg;
    logic                    dir_down_next;
    logic [WIDTH_W-1:0]      width_reg;
    logic [WIDTH_W-1:0]      width_next;
    logic                    dir_turn;
    logic [ANGLE_W-1:0]      angle_moved;
    logic [WIDTH_PROD_W-1:0] width_prod;

    always_comb begin
        // The direction turns at either end before the angle moves.
        dir_turn = dir_down_reg;
        if (!dir_down_reg && (angle_reg >= ANGLE_MAX)) begin
            dir_turn = 1'b1;
        end else if (dir_down_reg && (angle_reg == '0)) begin
            dir_turn = 1'b0;
        end

        angle_moved = angle_reg;
        if (dir_turn) begin
            if (angle_reg != '0) begin
                angle_moved = angle_reg - 1'b1;
            end
        end else if (angle_reg < ANGLE_MAX) begin
            angle_moved = angle_reg + 1'b1;
        end
        if (angle_moved > ANGLE_MAX) begin
            angle_moved = ANGLE_MAX;
        end
    end

    assign width_prod = WIDTH_PROD_W'(angle_moved) * WIDTH_PROD_W'(WIDTH_RECIP);

    always_comb begin
        angle_next    = angle_reg;
        dir_down_next = dir_down_reg;
        width_next    = width_reg;
        if (step_en) begin
            angle_next    = angle_moved;
            dir_down_next = dir_turn;
            width_next    = WIDTH_MIN + WIDTH_W'(width_prod >> WIDTH_SHIFT);
        end
    end

    assign angle_after  = angle_next;
    assign width_before = width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg    <= '0;
            dir_down_reg <= 1'b0;
            width_reg    <= WIDTH_MIN;
        end else begin
            angle_reg    <= angle_next;
            dir_down_reg <= dir_down_next;
            width_reg    <= width_next;
        end
    end

endmodule

FILE: rtl/core/ssrs_range.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanner range converter
// Turns an echo duration into a distance in centimeters, giving zero when no
// sample is due, when there is no echo, or when the echo exceeds the timeout.
// ----------------------------------------------------------------------------
module ssrs_range (
    input  logic [ssrs_pkg::ECHO_W-1:0]  echo_us,
    input  logic [ssrs_pkg::ECHO_W-1:0]  echo_timeout_us,
    input  logic                         sample,
    output logic [ssrs_pkg::DIST_W-1:0]  distance_cm
);
    import ssrs_pkg::*;

    logic [DIST_PROD_W-1:0] dist_prod;
    logic                   echo_ok;

    // Multiply by the scaled reciprocal of 20000/343 and keep the integer part.
    assign dist_prod = DIST_PROD_W'(echo_us) * DIST_PROD_W'(DIST_RECIP);
    assign echo_ok   = (echo_us != '0) && (echo_us <= echo_timeout_us);

    assign distance_cm = (sample && echo_ok) ? dist_prod[DIST_SHIFT +: DIST_W] : '0;

endmodule

FILE: dv/tb_servo_sweep_range_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo sweep range scanner testbench
// Streams millisecond ticks with echo durations into the scanner and checks
// every result transfer against a predictor of the three interval timers, the
// back-and-forth servo sweep and the range computation. A directed opening
// covers field extremes, timer wrap and echo limits; random phases follow
// under several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_servo_sweep_range_scanner_top;

    import ssrs_pkg::*;

    typedef struct {
        bit        pulse_fire;
        bit [10:0] pulse_width_us;
        bit        sample_fire;
        bit [7:0]  sample_angle;
        bit [10:0] distance_cm;
    } scan_result_t;

    // Predicts one scanner result per tick and compares result transfers.
    class scan_scoreboard;
        bit [15:0]      pulse_ival;
        bit [15:0]      step_ival;
        bit [15:0]      sample_ival;
        bit [15:0]      echo_limit;
        bit [7:0]       angle;
        bit             going_down;
        bit [10:0]      width;
        bit [31:0]      last_pulse;
        bit [31:0]      last_step;
        bit [31:0]      last_sample;
        scan_result_t   expected_q[$];
        int             errors;

        function new();
            pulse_ival  = PULSE_IVAL_RST;
            step_ival   = STEP_IVAL_RST;
            sample_ival = SAMPLE_IVAL_RST;
            echo_limit  = ECHO_TIMEOUT_RST;
            angle       = '0;
            going_down  = 1'b0;
            width       = servo_width(8'd0);
            last_pulse  = '0;
            last_step   = '0;
            last_sample = '0;
            errors      = 0;
        endfunction

        function bit [10:0] servo_width(bit [7:0] deg);
            int unsigned span;
            span = (int'(deg) * 1000) / int'(ANGLE_MAX);
            return WIDTH_MIN + span[10:0];
        endfunction

        // Wrap-safe interval test; the timer restarts when it fires.
        function bit interval_due(input bit [31:0] now, inout bit [31:0] last,
                                  input bit [15:0] ival);
            bit [31:0] gap;
            gap = now - last;
            if (gap >= {16'd0, ival}) begin
                last = now;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void write_reg(bit [7:0] idx, bit [15:0] val);
            case (idx)
                REG_PULSE_IVAL:   pulse_ival  = val;
                REG_STEP_IVAL:    step_ival   = val;
                REG_SAMPLE_IVAL:  sample_ival = val;
                REG_ECHO_TIMEOUT: echo_limit  = val;
                default: ;
            endcase
        endfunction

        function void note_input(bit [31:0] now, bit [15:0] echo);
            scan_result_t r;
            bit [31:0]    prod;
            r.pulse_width_us = width;
            r.pulse_fire     = interval_due(now, last_pulse, pulse_ival);
            if (interval_due(now, last_step, step_ival)) begin
                if (!going_down && angle >= ANGLE_MAX)
                    going_down = 1'b1;
                else if (going_down && angle == 0)
                    going_down = 1'b0;
                if (going_down) begin
                    if (angle > 0)
                        angle = angle - 8'd1;
                end else if (angle < ANGLE_MAX) begin
                    angle = angle + 8'd1;
                end
                width = servo_width(angle);
            end
            r.sample_fire  = interval_due(now, last_sample, sample_ival);
            r.sample_angle = angle;
            r.distance_cm  = '0;
            if (r.sample_fire && echo != 0 && echo <= echo_limit) begin
                prod          = {16'd0, echo} * 32'd343;
                prod          = prod / 32'd20000;
                r.distance_cm = prod[10:0];
            end
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val != act_val) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(bit [31:0] data);
            scan_result_t r;
            if (expected_q.size() == 0) begin
                $error("result transfer 0x%08h with no expected result pending", data);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            check_field("pulse_fire", r.pulse_fire, data[0]);
            check_field("pulse_width_us", r.pulse_width_us, data[11:1]);
            check_field("sample_fire", r.sample_fire, data[12]);
            check_field("sample_angle", r.sample_angle, data[20:13]);
            check_field("distance_cm", r.distance_cm, data[31:21]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [31:0] now_ms, [47:32] echo_us
    logic [IN_W-1:0]       s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [0] pulse_fire, [11:1] pulse_width_us, [12] sample_fire,
    // [20:13] sample_angle, [31:21] distance_cm
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [IVAL_W-1:0]     cfg_wr_data;

    scan_scoreboard sb;
    bit             steady;
    bit [31:0]      cur_now;
    bit [15:0]      cur_timeout;

    servo_sweep_range_scanner_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stall bursts, long ready stretches, none once steady.
    initial begin
        m_axis_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (steady) begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                case ($urandom_range(0, 7))
                    0, 1: begin
                        m_axis_tready <= 1'b0;
                        repeat ($urandom_range(1, 15)) @(posedge aclk);
                    end
                    2: begin
                        m_axis_tready <= 1'b1;
                        repeat ($urandom_range(40, 80)) @(posedge aclk);
                    end
                    default: begin
                        m_axis_tready <= 1'b1;
                        repeat ($urandom_range(1, 20)) @(posedge aclk);
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Leaves tvalid high so a following item can go out with no idle gap.
    task automatic send_item(input bit [31:0] now, input bit [15:0] echo);
        s_axis_tdata  <= {echo, now};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_input(now, echo);
    endtask

    task automatic idle_input(input int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input bit [7:0] idx, input bit [15:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // Writes all four registers plus one unused index, which must be ignored.
    task automatic load_config(input bit [15:0] pulse, input bit [15:0] stp,
                               input bit [15:0] smp, input bit [15:0] tmo);
        write_reg(REG_PULSE_IVAL, pulse);
        write_reg(REG_STEP_IVAL, stp);
        write_reg(REG_SAMPLE_IVAL, smp);
        write_reg(REG_ECHO_TIMEOUT, tmo);
        write_reg(8'($urandom_range(4, 255)), 16'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        cur_timeout = tmo;
    endtask

    task automatic next_time(input int unsigned span);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            cur_now = cur_now + $urandom_range(0, 3);
        else if (r < 88)
            cur_now = cur_now + $urandom_range(0, span);
        else if (r < 95)
            cur_now = $urandom;
        else
            cur_now = 32'hFFFF_FFFF - $urandom_range(0, 3);
    endtask

    function automatic bit [15:0] pick_echo();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 20) return cur_timeout;
        if (r < 30) return cur_timeout + 16'd1;
        if (r < 38) return 16'hFFFF;
        if (r < 70) return 16'($urandom_range(0, cur_timeout));
        return 16'($urandom);
    endfunction

    task automatic run_random(input int count, input int unsigned span,
                              input int idle_odds, input int calm_from);
        for (int i = 0; i < count; i++) begin
            if (i == calm_from)
                steady = 1'b1;
            if (!steady && $urandom_range(1, idle_odds) == 1)
                idle_input($urandom_range(1, 15));
            next_time(span);
            send_item(cur_now, pick_echo());
        end
    endtask

    task automatic run_directed();
        bit [31:0] d_now  [16] = '{32'h0000_0000, 32'd19, 32'd20, 32'd30, 32'd70,
                                   32'd140, 32'd210, 32'd280, 32'd350, 32'hFFFF_FFFF,
                                   32'h0000_0044, 32'h0000_0045, 32'h8000_0000,
                                   32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA};
        bit [15:0] d_echo [16] = '{16'd0, 16'hFFFF, 16'd8000, 16'd8001, 16'd8000,
                                   16'd8001, 16'd0, 16'd1, 16'd59, 16'hAAAA,
                                   16'h5555, 16'd7999, 16'h7FFF, 16'h8000,
                                   16'd1234, 16'd4000};
        for (int i = 0; i < 16; i++) begin
            if (i % 5 == 4)
                idle_input($urandom_range(1, 15));
            send_item(d_now[i], d_echo[i]);
        end
        cur_now = d_now[15];
    endtask

    initial begin
        sb            = new();
        steady        = 1'b0;
        cur_now       = '0;
        cur_timeout   = ECHO_TIMEOUT_RST;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = '0;
        cfg_wr_data   = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Register defaults: timer thresholds, wrap of the time stamp, echo limits.
        run_directed();
        wait_drain();

        // Step and sample on every tick so the sweep reaches both ends and turns.
        load_config(16'd1, 16'd0, 16'd0, 16'hFFFF);
        run_random(380, 4, 12, -1);
        wait_drain();

        // Longest intervals with a zero timeout: every nonzero echo reads as zero.
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        run_random(100, 140000, 5, -1);
        wait_drain();

        load_config(16'($urandom_range(1, 100)), 16'($urandom_range(1, 100)),
                    16'($urandom_range(1, 100)), 16'($urandom_range(1, 65535)));
        run_random(100, 200, 5, -1);
        wait_drain();
        run_random(100, 200, 5, -1);
        wait_drain();

        load_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_random(150, 140000, 5, -1);
        wait_drain();

        load_config(PULSE_IVAL_RST, STEP_IVAL_RST, SAMPLE_IVAL_RST, ECHO_TIMEOUT_RST);
        run_random(300, 200, 5, 150);
        wait_drain();

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
